>>> sv/rrle_pkg.sv
// ----------------------------------------------------------------------------
// rrle_pkg
// Shared constants, register indexes and types of the Rice run-length encoder.
// ----------------------------------------------------------------------------
package rrle_pkg;

  // Largest effective Rice k; rice_k saturates here
  localparam int MAX_K     = 15;
  // Width of the rice_k register and of the run counter
  localparam int K_W       = 4;
  localparam int CNT_W     = 15;
  // Effective k, divisor m and the longest code word one source bit can cause
  localparam int KE_W      = $clog2(MAX_K + 1);
  localparam int M_W       = MAX_K + 1;
  localparam int CODE_W    = MAX_K + 4;
  localparam int LEN_W     = $clog2(CODE_W + 1);
  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = K_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MPS_SYMBOL = 2'd0,
    REG_RICE_K     = 2'd1
  } reg_idx_t;

  // Live configuration seen by the encoder
  typedef struct packed {
    logic            mps;
    logic [KE_W-1:0] k;
  } cfg_t;

  // Code word handed to the serializer, right aligned, sent MSB first
  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } load_t;

endpackage

>>> sv/rrle_in_if.sv
// ----------------------------------------------------------------------------
// rrle_in_if
// Source bit channel: valid/ready with one source bit and its end marker.
// ----------------------------------------------------------------------------
interface rrle_in_if;
  logic valid;
  logic ready;
  logic in_bit;
  logic stream_end;

  modport source (output valid, output in_bit, output stream_end, input ready);
  modport sink   (input valid, input in_bit, input stream_end, output ready);
endinterface

>>> sv/rrle_out_if.sv
// ----------------------------------------------------------------------------
// rrle_out_if
// Code bit channel: valid/ready with one code bit and its last-of-item flag.
// ----------------------------------------------------------------------------
interface rrle_out_if;
  logic valid;
  logic ready;
  logic code_bit;
  logic item_last;

  modport source (output valid, output code_bit, output item_last, input ready);
  modport sink   (input valid, input code_bit, input item_last, output ready);
endinterface

>>> sv/rrle_cfg_if.sv
// ----------------------------------------------------------------------------
// rrle_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface rrle_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrle_pkg::CFG_IDX_W-1:0] index;
  logic [rrle_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/rrle_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrle_cfg_regs
// Configuration registers (mps_symbol, rice_k) and the saturated k.
// ----------------------------------------------------------------------------
module rrle_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  rrle_cfg_if.sink       cfg_s,
  output rrle_pkg::cfg_t cfg
);
  import rrle_pkg::*;

  logic           mps_r;
  logic [K_W-1:0] rice_k_r;

  // Writes are always taken; unknown indexes fall through
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mps_r    <= 1'b1;
      rice_k_r <= '0;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        REG_MPS_SYMBOL: mps_r    <= cfg_s.data[0];
        REG_RICE_K:     rice_k_r <= cfg_s.data[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective k, saturated to MAX_K
  always_comb begin
    cfg.mps = mps_r;
    if (32'(rice_k_r) > MAX_K) cfg.k = KE_W'(MAX_K);
    else                       cfg.k = KE_W'(rice_k_r);
  end
endmodule

>>> sv/rrle_encoder.sv
// ----------------------------------------------------------------------------
// rrle_encoder
// Run counter and header state; builds the whole code word of one source bit.
// ----------------------------------------------------------------------------
module rrle_encoder (
  input  logic            clk,
  input  logic            rst_n,
  input  rrle_pkg::cfg_t  cfg,
  input  logic            accept,
  input  logic            in_bit,
  input  logic            stream_end,
  output rrle_pkg::load_t load
);
  import rrle_pkg::*;

  logic [CNT_W-1:0]  run_count_r, run_count_nxt;
  logic              header_done_r, header_done_nxt;

  logic              is_mps;
  logic [M_W-1:0]    m_val;
  logic [CNT_W-1:0]  cnt_inc;
  logic              fill;
  logic [CNT_W-1:0]  rem_src;
  logic [CODE_W-1:0] rem_mask;
  logic [CODE_W-1:0] rem;
  logic [1:0]        pre_val;
  logic [LEN_W-1:0]  pre_len;
  logic [CODE_W-1:0] body_val;
  logic [LEN_W-1:0]  body_len;
  logic [LEN_W-1:0]  k_len;

  assign is_mps   = (in_bit == cfg.mps);
  assign m_val    = M_W'(1) << cfg.k;
  assign cnt_inc  = run_count_r + CNT_W'(1);
  assign fill     = is_mps && (32'(cnt_inc) >= 32'(m_val));
  assign rem_src  = is_mps ? (fill ? '0 : cnt_inc) : run_count_r;
  assign rem_mask = (CODE_W'(1) << cfg.k) - CODE_W'(1);
  assign rem      = CODE_W'(rem_src) & rem_mask;
  assign k_len    = LEN_W'(cfg.k);

  // Prefix: optional header bit, then optional run-fill 1
  always_comb begin
    pre_val = 2'b00;
    pre_len = '0;
    if (!header_done_r && fill) begin
      pre_val = {cfg.mps, 1'b1};
      pre_len = LEN_W'(2);
    end else if (!header_done_r) begin
      pre_val = {1'b0, cfg.mps};
      pre_len = LEN_W'(1);
    end else if (fill) begin
      pre_val = 2'b01;
      pre_len = LEN_W'(1);
    end
  end

  // Body: 0, k-bit remainder, then trailer where the stream ends
  always_comb begin
    body_val = '0;
    body_len = '0;
    if (is_mps) begin
      if (stream_end) begin
        body_val = rem << 1;
        body_len = k_len + LEN_W'(2);
      end
    end else if (stream_end) begin
      body_val = (rem << 1) | CODE_W'(1);
      body_len = k_len + LEN_W'(2);
    end else begin
      body_val = rem;
      body_len = k_len + LEN_W'(1);
    end
  end

  always_comb begin
    load.word = (CODE_W'(pre_val) << body_len) | body_val;
    load.len  = pre_len + body_len;
    load.vld  = accept && (load.len != '0);
  end

  // Stream state; end of stream starts a fresh stream
  always_comb begin
    header_done_nxt = header_done_r;
    run_count_nxt   = run_count_r;
    if (accept) begin
      header_done_nxt = !stream_end;
      if (stream_end || !is_mps || fill) run_count_nxt = '0;
      else                               run_count_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_done_r <= 1'b0;
      run_count_r   <= '0;
    end else begin
      header_done_r <= header_done_nxt;
      run_count_r   <= run_count_nxt;
    end
  end
endmodule

>>> sv/rrle_serializer.sv
// ----------------------------------------------------------------------------
// rrle_serializer
// Result register: holds one code word and shifts it out a bit per transfer.
// ----------------------------------------------------------------------------
module rrle_serializer (
  input  logic            clk,
  input  logic            rst_n,
  input  rrle_pkg::load_t load,
  output logic            can_load,
  rrle_out_if.source      out_m
);
  import rrle_pkg::*;

  logic [CODE_W-1:0] word_r, word_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  bit_idx;

  assign bit_idx         = cnt_r - LEN_W'(1);
  assign out_m.valid     = (cnt_r != '0);
  assign out_m.code_bit  = word_r[bit_idx[$clog2(CODE_W)-1:0]];
  assign out_m.item_last = (cnt_r == LEN_W'(1));

  // Free when empty or when the final bit leaves this cycle
  assign can_load = (cnt_r == '0) || (out_m.item_last && out_m.ready);

  always_comb begin
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    if (load.vld) begin
      word_nxt = load.word;
      cnt_nxt  = load.len;
    end else if (out_m.valid && out_m.ready) begin
      cnt_nxt  = cnt_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    word_r <= word_nxt;
  end
endmodule

>>> sv/rice_run_length_bit_encoder_unit.sv
// ----------------------------------------------------------------------------
// rice_run_length_bit_encoder_unit
// Golomb-Rice run-length encoder for a binary source, m = 2^k.
// ----------------------------------------------------------------------------
// One source bit is taken per transfer and turned at once into its whole code
// word, which a result register then sends one code bit per cycle while the
// sink is ready. A source bit that causes no code bit or a single code bit does
// not hold the input, so with a ready sink a run of more-probable bits streams
// at one bit per clock. A bit that causes n code bits (header, run fill, 0 plus
// k remainder bits, trailer: up to k+4) holds the input until they have drained
// through the one-bit-wide output; the next source bit is taken in the cycle the
// last code bit transfers. rice_k above MAX_K acts as MAX_K. Configuration writes are meant for an idle block.
// ----------------------------------------------------------------------------
module rice_run_length_bit_encoder_unit (
  input  logic      clk,
  input  logic      rst_n,
  rrle_in_if.sink   in_s,
  rrle_out_if.source out_m,
  rrle_cfg_if.sink  cfg_s
);
  import rrle_pkg::*;

  cfg_t  cfg;
  load_t load;
  logic  can_load;
  logic  accept;

  assign in_s.ready = can_load;
  assign accept     = in_s.valid && can_load;

  // Configuration registers
  rrle_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .cfg   (cfg)
  );

  // Code word construction and run state
  rrle_encoder u_enc (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .accept     (accept),
    .in_bit     (in_s.in_bit),
    .stream_end (in_s.stream_end),
    .load       (load)
  );

  // Output register and bit shifter
  rrle_serializer u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .can_load (can_load),
    .out_m    (out_m)
  );
endmodule

>>> sv/rrle_checker.sv
// ----------------------------------------------------------------------------
// rrle_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rrle_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic code_bit,
  input logic item_last
);

  // A stalled code bit holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_bit) && $stable(item_last))
    else $error("code bit changed while stalled");

  // An empty block always takes a source bit
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output empty");

  // While a code word is on show, input is only taken with its final code bit
  a_ready_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> item_last)
    else $error("input ready in the middle of a code word");

  // A code word drains without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !item_last |=> out_valid)
    else $error("gap inside a code word");

endmodule

bind rice_run_length_bit_encoder_unit rrle_checker u_rrle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .code_bit  (out_m.code_bit),
  .item_last (out_m.item_last)
);

>>> tb/tb_rice_run_length_bit_encoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rice_run_length_bit_encoder_unit
// Self-checking bench for the Golomb-Rice run-length bit encoder.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the symbol and k registers, the run
// counter and the header flag, and turns every accepted source bit into the
// code bits it must produce. Each code bit transfer is compared against the
// oldest predicted bit. Stimulus runs a short directed set (reset defaults,
// both symbol polarities, k = 0 and k = 15, k lowered over a pending run),
// then random phases of well-formed runs plus noise, with bursty source
// traffic and a patterned, sometimes long, sink stall.
// ----------------------------------------------------------------------------
module tb_rice_run_length_bit_encoder_unit;
  import rrle_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 300;
  localparam int RAND_BITS   = 230;

  // Index past the register map; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic code_bit;
    logic item_last;
  } code_exp_t;

  // Predicts the code bit stream and checks the transfers against it
  class rice_code_scoreboard;
    logic             mps;
    logic [K_W-1:0]   k_reg;
    logic [CNT_W-1:0] run_count;
    logic             header_done;
    code_exp_t        code_q[$];
    int unsigned      bits_noted;
    int unsigned      streams_closed;
    int unsigned      codes_checked;
    int unsigned      mismatches;

    function new();
      mps            = 1'b1;
      k_reg          = '0;
      run_count      = '0;
      header_done    = 1'b0;
      bits_noted     = 0;
      streams_closed = 0;
      codes_checked  = 0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_MPS_SYMBOL: mps = val[0];
        REG_RICE_K:     k_reg = val[K_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_code(logic b);
      code_exp_t e;
      e.code_bit  = b;
      e.item_last = 1'b0;
      code_q = {code_q, e};
    endfunction

    // k-bit remainder of the run count, MSB first
    function void push_remainder(int unsigned ke);
      for (int i = int'(ke) - 1; i >= 0; i--) push_code(run_count[i]);
    endfunction

    function void note_source(logic src_bit, logic src_end);
      int unsigned ke;
      int unsigned m;
      int unsigned first;
      first = code_q.size();
      ke    = (k_reg > MAX_K) ? MAX_K : k_reg;
      m     = 1 << ke;
      bits_noted++;
      if (!header_done) begin
        push_code(mps);
        header_done = 1'b1;
      end
      if (src_bit == mps) begin
        // counter is CNT_W wide and wraps
        run_count = run_count + 1'b1;
        if (run_count >= m) begin
          push_code(1'b1);
          run_count = '0;
        end
        // flush of the pending run, trailer 0
        if (src_end) begin
          push_code(1'b0);
          push_remainder(ke);
          push_code(1'b0);
        end
      end else begin
        push_code(1'b0);
        push_remainder(ke);
        run_count = '0;
        if (src_end) push_code(1'b1);
      end
      if (src_end) begin
        run_count   = '0;
        header_done = 1'b0;
        streams_closed++;
      end
      if (code_q.size() > first) code_q[code_q.size() - 1].item_last = 1'b1;
    endfunction

    function void check_code(logic got_bit, logic got_last);
      code_exp_t e;
      if (code_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: code bit %0b (item_last %0b) with nothing predicted",
                   $time, got_bit, got_last);
        return;
      end
      e = code_q.pop_front();
      codes_checked++;
      if (got_bit !== e.code_bit || got_last !== e.item_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: code bit #%0d: exp bit %0b last %0b, got bit %0b last %0b",
                   $time, codes_checked, e.code_bit, e.item_last, got_bit, got_last);
      end
    endfunction

    function int unsigned pending();
      return code_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rrle_in_if  in_ch ();
  rrle_out_if out_ch ();
  rrle_cfg_if cfg_ch ();

  rice_code_scoreboard sb = new();

  int          cycle_cnt     = 0;
  int          hold_requests = 0;
  int          src_sent      = 0;
  int          burst_left    = 0;
  bit          gaps_on       = 1'b1;

  rice_run_length_bit_encoder_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch),
    .cfg_s (cfg_ch)
  );

  always #5 clk = ~clk;

  // Cycle budget
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("rice_run_length_bit_encoder_unit regression: fail");
      $finish;
    end
  end

  // Transfer monitor: register writes, source bits, code bits
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_source(in_ch.in_bit, in_ch.stream_end);
      if (out_ch.valid && out_ch.ready) sb.check_code(out_ch.code_bit, out_ch.item_last);
    end
  end

  // Code bit sink: patterned stalls, plus long hold-offs on request
  initial begin : code_sink
    int mode;
    int span;
    int hold_left;
    int holds_done;
    int tick;
    mode       = 0;
    span       = 0;
    hold_left  = 0;
    holds_done = 0;
    tick       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_requests > holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 64);
        end
        span--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (tick % 4 != 0);
        endcase
      end
    end
  end

  // One source bit transfer, with a random gap at the start of each burst
  task automatic send_src(input logic src_bit, input logic src_end);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid      <= 1'b0;
        in_ch.in_bit     <= 1'($urandom_range(0, 1));
        in_ch.stream_end <= 1'($urandom_range(0, 1));
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.in_bit     <= src_bit;
    in_ch.stream_end <= src_end;
    do @(posedge clk); while (!in_ch.ready);
    src_sent++;
  endtask

  task automatic send_run(input logic src_bit, input int count);
    repeat (count) send_src(src_bit, 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop the source and wait until every predicted code bit has transferred
  task automatic drain(input int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  initial begin : main_seq
    logic                 cur_mps;
    logic [K_W-1:0]       k_sel;
    logic [CFG_DAT_W-1:0] mdata;
    int                   pick;
    int                   rand_goal;
    int                   stop_at;
    int                   run_max;
    int                   run_len;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.in_bit     <= 1'b0;
    in_ch.stream_end <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: mps 1, k 0 (every more-probable bit fills a run)
    send_src(1'b1, 1'b0);
    send_src(1'b1, 1'b0);
    send_src(1'b0, 1'b0);
    send_src(1'b1, 1'b1);
    send_src(1'b0, 1'b1);
    drain(SETTLE);

    // Unmapped index ignored; mps 0 with upper data bits set, k 2
    write_reg(REG_UNMAPPED, 4'hF);
    write_reg(REG_MPS_SYMBOL, 4'b1110);
    write_reg(REG_RICE_K, 4'd2);
    send_run(1'b0, 4);
    send_src(1'b1, 1'b0);
    send_src(1'b0, 1'b0);
    send_src(1'b0, 1'b1);
    drain(SETTLE);

    // Largest k: single-bit streams ending on each symbol
    write_reg(REG_MPS_SYMBOL, 4'b0001);
    write_reg(REG_RICE_K, 4'd15);
    send_src(1'b1, 1'b1);
    send_src(1'b0, 1'b1);
    drain(SETTLE);

    // k lowered below a pending run: fill on the next mps bit
    write_reg(REG_RICE_K, 4'd3);
    send_run(1'b1, 7);
    drain(SETTLE);
    write_reg(REG_RICE_K, 4'd1);
    send_src(1'b1, 1'b0);
    drain(SETTLE);

    // k lowered below a pending run: remainder keeps the low k bits
    write_reg(REG_RICE_K, 4'd3);
    send_run(1'b1, 5);
    drain(SETTLE);
    write_reg(REG_RICE_K, 4'd1);
    send_src(1'b0, 1'b1);
    drain(SETTLE);

    // Back-pressure: long sink hold while 16-bit code words keep coming
    write_reg(REG_RICE_K, 4'd15);
    write_reg(REG_MPS_SYMBOL, 4'b0001);
    cur_mps = 1'b1;
    hold_requests++;
    send_run(1'b0, 20);
    send_src(1'b0, 1'b1);
    drain(SETTLE);

    // Random phases: new settings, then runs closed by lpb or stream end
    rand_goal = src_sent + RAND_BITS;
    while (src_sent < rand_goal) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      k_sel = '0;
      else if (pick == 1) k_sel = 4'd15;
      else if (pick < 8)  k_sel = 4'($urandom_range(0, 4));
      else                k_sel = 4'($urandom_range(5, 15));
      mdata    = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: begin
          write_reg(REG_RICE_K, k_sel);
          write_reg(REG_MPS_SYMBOL, mdata);
          cur_mps = mdata[0];
        end
        1: write_reg(REG_RICE_K, k_sel);
        default: begin
          write_reg(REG_MPS_SYMBOL, mdata);
          write_reg(REG_RICE_K, k_sel);
          cur_mps = mdata[0];
        end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      run_max = (k_sel <= 3) ? (2 << k_sel) + 2 : 20;
      stop_at = src_sent + $urandom_range(15, 45);
      while (src_sent < stop_at) begin
        if ($urandom_range(0, 9) < 8) begin
          run_len = $urandom_range(0, run_max);
          send_run(cur_mps, run_len);
          case ($urandom_range(0, 5))
            0:       send_src(cur_mps, 1'b1);
            1:       send_src(~cur_mps, 1'b1);
            default: send_src(~cur_mps, 1'b0);
          endcase
        end else begin
          send_src(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
        end
      end
      drain(SETTLE);
    end

    drain(40);
    $display("covered %0d source bits, %0d closed streams, %0d code bits checked",
             sb.bits_noted, sb.streams_closed, sb.codes_checked);
    $display("k 0..15, both symbols, k cut over a pending run, %0d-cycle hold",
             LONG_HOLD);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("rice_run_length_bit_encoder_unit regression: pass");
    end else begin
      $display("rice_run_length_bit_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> rice_run_length_bit_encoder_unit.f
sv/rrle_pkg.sv
sv/rrle_in_if.sv
sv/rrle_out_if.sv
sv/rrle_cfg_if.sv
sv/rrle_cfg_regs.sv
sv/rrle_encoder.sv
sv/rrle_serializer.sv
sv/rice_run_length_bit_encoder_unit.sv
sv/rrle_checker.sv
tb/tb_rice_run_length_bit_encoder_unit.sv
